[design/multiset_mex_tracker_assert.svh]
// assertion macros for the multiset mex tracker checker
// needs a clock named clk and an active-low reset named arst_n in scope
`ifndef MULTISET_MEX_TRACKER_ASSERT_SVH
`define MULTISET_MEX_TRACKER_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define MMT_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("mex tracker check failed");

// antecedent implies consequent in the next cycle
`define MMT_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("mex tracker check failed");

`endif

[design/mmt_pkg.sv]
// shared types, constants and helpers for the multiset mex tracker
// no dependencies
`default_nettype none

package mmt_pkg;

	localparam int VALUE_W    = 32;
	localparam int WORD_W     = 64;
	localparam int WORD_IDX_W = 6;
	localparam int MEX_OUT_W  = 9;

	// controller to datapath
	typedef struct packed {
		logic capture;
		logic update;
		logic scan_step;
		logic latch_res;
		logic load_out;
	} mmt_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic hit;
		logic last;
	} mmt_sts_t;

	// lowest clear bit of a presence word
	function automatic logic [WORD_IDX_W-1:0] first_zero(input logic [WORD_W-1:0] w);
		logic [WORD_IDX_W-1:0] idx;
		idx = '0;
		for (int i = WORD_W - 1; i >= 0; i--) begin
			if (!w[i]) idx = WORD_IDX_W'(i);
		end
		return idx;
	endfunction

endpackage

`default_nettype wire

[design/multiset_mex_tracker.sv]
// top level of the multiset mex tracker: controller plus datapath
// depends on mmt_pkg, mmt_ctrl, mmt_dp (and mmt_ram through the datapath)
//
//   channel  direction  handshake             payload
//   in       input      in_valid / in_ready   command, value
//   out      output     out_valid / out_ready mex, mex_capped, error
//
// one request at a time: accept, count update, then a word-serial find-first-zero
// over the 64-bit presence words until the first clear bit or the last word, then
// the hand-off to the output register, which waits until that register is free;
// the result sits in an output register, so the next request is taken while
// the previous result still waits on out_ready
// reset clears the presence bitmap at once; the count ram needs no clearing,
// since a count whose presence bit is clear reads as zero
`default_nettype none

module multiset_mex_tracker
	import mmt_pkg::*;
#(
	parameter int VALUES     = 256,
	parameter int COUNT_BITS = 16
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic                 command,
	input  wire logic [VALUE_W-1:0]   value,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic      [MEX_OUT_W-1:0] mex,
	output logic                      mex_capped,
	output logic                      error
);

	// command and status between sequencer and datapath
	mmt_cmd_t cmd;
	mmt_sts_t sts;

	// sequencer: owns the handshakes and the output valid flag
	mmt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// datapath: counts in ram, presence bits in flops, scan and result registers
	mmt_dp #(
		.VALUES    (VALUES),
		.COUNT_BITS(COUNT_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.command   (command),
		.value     (value),
		.cmd       (cmd),
		.sts       (sts),
		.mex       (mex),
		.mex_capped(mex_capped),
		.error     (error)
	);

endmodule

`default_nettype wire

[design/mmt_ram.sv]
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module mmt_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		if (re) rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

[design/mmt_ctrl.sv]
// sequencer for the mex tracker: accept, count update, word scan, result hand-off
// depends on mmt_pkg
`default_nettype none

module mmt_ctrl
	import mmt_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  wire logic     out_ready,
	input  wire mmt_sts_t sts,
	output mmt_cmd_t      cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_UPDATE,
		ST_SCAN,
		ST_DONE
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

	always_comb begin
		cmd           = '0;
		cmd.capture   = (state_q == ST_IDLE) && in_valid;
		cmd.update    = (state_q == ST_UPDATE);
		cmd.scan_step = (state_q == ST_SCAN) && !sts.hit && !sts.last;
		cmd.latch_res = (state_q == ST_SCAN) && (sts.hit || sts.last);
		cmd.load_out  = (state_q == ST_DONE) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) state_q <= ST_UPDATE;
				end
				ST_UPDATE: begin
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (sts.hit || sts.last) state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (cmd.load_out) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

endmodule

`default_nettype wire

[design/mmt_dp.sv]
// datapath: count ram, presence bitmap, find-first-zero word scan, result registers
// depends on mmt_pkg and mmt_ram
`default_nettype none

module mmt_dp
	import mmt_pkg::*;
#(
	parameter int VALUES     = 256,
	parameter int COUNT_BITS = 16
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 command,
	input  wire logic [VALUE_W-1:0]   value,
	input  wire mmt_cmd_t             cmd,
	output mmt_sts_t                  sts,
	output logic      [MEX_OUT_W-1:0] mex,
	output logic                      mex_capped,
	output logic                      error
);

	localparam int AW    = $clog2(VALUES);
	localparam int WORDS = (VALUES + WORD_W - 1) / WORD_W;
	localparam int WB    = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int PAD_W = WORDS * WORD_W;
	localparam int MEX_W = $clog2(VALUES + 1);

	logic                  cmd_q;
	logic                  tracked_q;
	logic [AW-1:0]         idx_q;
	logic [VALUES-1:0]     presence_q;
	logic [WB-1:0]         ws_q;
	logic [MEX_W-1:0]      res_mex_q;
	logic                  res_capped_q;
	logic                  res_err_q;
	logic [MEX_W-1:0]      mex_q;
	logic                  capped_q;
	logic                  error_q;

	logic [COUNT_BITS-1:0] rdata;
	logic [COUNT_BITS-1:0] old_count;
	logic [COUNT_BITS-1:0] new_count;
	logic                  present;
	logic                  err_now;
	logic                  we;
	logic [PAD_W-1:0]      padded;
	logic [WORD_W-1:0]     word;

	mmt_ram #(
		.WIDTH(COUNT_BITS),
		.DEPTH(VALUES)
	) u_counts (
		.clk  (clk),
		.we   (we),
		.waddr(idx_q),
		.wdata(new_count),
		.re   (cmd.capture),
		.raddr(value[AW-1:0]),
		.rdata(rdata)
	);

	// a clear presence bit marks the count as zero, whatever the ram holds
	assign present   = presence_q[idx_q];
	assign old_count = present ? rdata : '0;
	assign new_count = cmd_q ? (old_count - 1'b1) : (old_count + 1'b1);
	assign err_now   = tracked_q && (cmd_q ? !present : (old_count == '1));
	assign we        = cmd.update && tracked_q && !err_now;

	// pad bits read as present so the scan never stops on them
	always_comb begin
		padded               = '1;
		padded[VALUES-1:0]   = presence_q;
	end

	assign word     = padded[{ws_q, WORD_IDX_W'(0)} +: WORD_W];
	assign sts.hit  = (word != '1);
	assign sts.last = (ws_q == WB'(WORDS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			presence_q <= '0;
		end else if (we) begin
			if (!cmd_q) presence_q[idx_q] <= 1'b1;
			else if (new_count == '0) presence_q[idx_q] <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			cmd_q     <= command;
			tracked_q <= (value < VALUE_W'(VALUES));
			idx_q     <= value[AW-1:0];
		end
		if (cmd.update) begin
			res_err_q <= err_now;
			ws_q      <= '0;
		end
		if (cmd.scan_step) ws_q <= ws_q + 1'b1;
		if (cmd.latch_res) begin
			res_mex_q    <= sts.hit ? MEX_W'({ws_q, first_zero(word)}) : MEX_W'(VALUES);
			res_capped_q <= !sts.hit;
		end
		if (cmd.load_out) begin
			mex_q    <= res_mex_q;
			capped_q <= res_capped_q;
			error_q  <= res_err_q;
		end
	end

	assign mex        = MEX_OUT_W'(mex_q);
	assign mex_capped = capped_q;
	assign error      = error_q;

endmodule

`default_nettype wire

[design/mmt_checker.sv]
// port-level checks for the multiset mex tracker, bound to the top level
// depends on mmt_pkg and multiset_mex_tracker_assert.svh
`default_nettype none
`include "multiset_mex_tracker_assert.svh"

module mmt_checker
	import mmt_pkg::*;
#(
	parameter int VALUES = 256
) (
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 in_valid,
	input wire logic                 in_ready,
	input wire logic                 out_valid,
	input wire logic                 out_ready,
	input wire logic [MEX_OUT_W-1:0] mex,
	input wire logic                 mex_capped,
	input wire logic                 error
);

	// a stalled result holds
	`MMT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(mex) && $stable(mex_capped) && $stable(error))
	// one request at a time: busy right after an accept
	`MMT_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
	// no result appears right after an accept
	`MMT_ASSERT_NEXT(a_no_early_result, in_valid && in_ready, !$rose(out_valid))
	// capped result reports the saturated mex
	`MMT_ASSERT_SAME(a_capped_mex, out_valid && mex_capped, mex == MEX_OUT_W'(VALUES))

endmodule

bind multiset_mex_tracker mmt_checker #(
	.VALUES(VALUES)
) u_mmt_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.mex       (mex),
	.mex_capped(mex_capped),
	.error     (error)
);

`default_nettype wire

[tb/tb_multiset_mex_tracker.sv]
// self-checking testbench for the multiset mex tracker: directed table, random episodes,
// a back-to-back run on one value; results are checked against typed values or a local multiset model
// depends on mmt_pkg and the multiset_mex_tracker rtl
module tb_multiset_mex_tracker;
	timeunit 1ns;
	timeprecision 1ps;

	import mmt_pkg::*;

	localparam int VALUES         = 256;
	localparam int COUNT_BITS     = 16;
	localparam int RANDOM_ITEMS   = 1200;
	localparam int LONG_HOLD      = 200;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 20;
	localparam int REPORT_LIMIT   = 10;
	localparam int LAST_ADDS      = 8;

	localparam bit [COUNT_BITS-1:0] COUNT_MAX = '1;

	// request commands
	localparam bit CMD_ADD    = 1'b0;
	localparam bit CMD_REMOVE = 1'b1;

	// directed rows either carry a hand-written result or defer to the model
	localparam bit TYPED     = 1'b1;
	localparam bit PREDICTED = 1'b0;

	typedef struct packed {
		logic [MEX_OUT_W-1:0] mex;
		logic                 capped;
		logic                 err;
	} mex_result_t;

	typedef struct packed {
		bit                 cmd;
		bit [VALUE_W-1:0]   val;
		bit                 typed;
		bit [MEX_OUT_W-1:0] mex;
		bit                 capped;
		bit                 err;
	} directed_row_t;

	// kinds of random episode
	typedef enum int {
		EP_FILL,
		EP_FULL_FILL,
		EP_DRAIN,
		EP_NOISE
	} episode_t;

	// directed table: reset state, untracked values at both ends of the range, remove of an
	// absent value, multiple copies of one value, word boundaries of the presence bitmap
	localparam int DIRECTED_ROWS = 25;
	localparam directed_row_t DIRECTED [DIRECTED_ROWS] = '{
		'{CMD_REMOVE, 32'd0,           TYPED,     9'd0, 1'b0, 1'b1}, // nothing there yet
		'{CMD_ADD,    32'hFFFF_FFFF,   TYPED,     9'd0, 1'b0, 1'b0}, // untracked, top of range
		'{CMD_REMOVE, 32'hFFFF_FFFF,   TYPED,     9'd0, 1'b0, 1'b0}, // untracked remove, no error
		'{CMD_ADD,    32'd256,         TYPED,     9'd0, 1'b0, 1'b0}, // first untracked value
		'{CMD_REMOVE, 32'd256,         TYPED,     9'd0, 1'b0, 1'b0},
		'{CMD_ADD,    32'd255,         TYPED,     9'd0, 1'b0, 1'b0}, // last tracked value
		'{CMD_ADD,    32'd0,           TYPED,     9'd1, 1'b0, 1'b0},
		'{CMD_ADD,    32'd0,           TYPED,     9'd1, 1'b0, 1'b0}, // second copy
		'{CMD_REMOVE, 32'd0,           TYPED,     9'd1, 1'b0, 1'b0}, // one copy still left
		'{CMD_ADD,    32'd1,           TYPED,     9'd2, 1'b0, 1'b0},
		'{CMD_REMOVE, 32'd0,           TYPED,     9'd0, 1'b0, 1'b0}, // last copy gone
		'{CMD_REMOVE, 32'd0,           TYPED,     9'd0, 1'b0, 1'b1}, // remove below zero
		'{CMD_ADD,    32'd0,           TYPED,     9'd2, 1'b0, 1'b0},
		'{CMD_ADD,    32'h8000_0000,   TYPED,     9'd2, 1'b0, 1'b0},
		'{CMD_REMOVE, 32'd255,         TYPED,     9'd2, 1'b0, 1'b0},
		'{CMD_REMOVE, 32'd255,         TYPED,     9'd2, 1'b0, 1'b1},
		'{CMD_ADD,    32'd63,          PREDICTED, 9'd0, 1'b0, 1'b0},
		'{CMD_ADD,    32'd64,          PREDICTED, 9'd0, 1'b0, 1'b0},
		'{CMD_ADD,    32'd2,           PREDICTED, 9'd0, 1'b0, 1'b0},
		'{CMD_ADD,    32'h5555_5555,   PREDICTED, 9'd0, 1'b0, 1'b0},
		'{CMD_REMOVE, 32'hAAAA_AAAA,   PREDICTED, 9'd0, 1'b0, 1'b0},
		'{CMD_ADD,    32'd127,         PREDICTED, 9'd0, 1'b0, 1'b0},
		'{CMD_ADD,    32'd128,         PREDICTED, 9'd0, 1'b0, 1'b0},
		'{CMD_ADD,    32'd191,         PREDICTED, 9'd0, 1'b0, 1'b0},
		'{CMD_REMOVE, 32'd1,           PREDICTED, 9'd0, 1'b0, 1'b0}
	};

	logic                 clk        = 1'b0;
	logic                 arst_n     = 1'b0;
	logic                 in_valid   = 1'b0;
	logic                 in_ready;
	logic                 command    = CMD_ADD;
	logic [VALUE_W-1:0]   value      = '0;
	logic                 out_valid;
	logic                 out_ready  = 1'b0;
	logic [MEX_OUT_W-1:0] mex;
	logic                 mex_capped;
	logic                 error;

	// model of the multiset: one count per tracked value plus the presence bitmap
	bit [COUNT_BITS-1:0] tally [VALUES];
	bit [VALUES-1:0]     present;

	mex_result_t expected_results [$];

	// idling controls, changed per episode
	bit tx_bursty     = 1'b0;
	bit rx_bursty     = 1'b0;
	bit hold_off_req  = 1'b0;

	int unsigned fail_count    = 0;
	int unsigned items_sent    = 0;
	int unsigned quiet_cycles  = 0;

	multiset_mex_tracker #(
		.VALUES     (VALUES),
		.COUNT_BITS (COUNT_BITS)
	) uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.command    (command),
		.value      (value),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.mex        (mex),
		.mex_capped (mex_capped),
		.error      (error)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// apply one request to the model and return what the block should answer
	function automatic mex_result_t apply_request(input bit cmd, input bit [VALUE_W-1:0] val);
		mex_result_t res;
		int unsigned idx;
		res = '0;
		if (val < VALUES) begin
			idx = val;
			if (cmd == CMD_ADD) begin
				// a saturated count refuses further copies
				if (tally[idx] == COUNT_MAX) begin
					res.err = 1'b1;
				end else begin
					tally[idx]++;
					present[idx] = 1'b1;
				end
			end else begin
				if (tally[idx] == '0) begin
					res.err = 1'b1;
				end else begin
					tally[idx]--;
					if (tally[idx] == '0) present[idx] = 1'b0;
				end
			end
		end
		// lowest clear bit, or VALUES when the bitmap is full
		res.mex = MEX_OUT_W'(VALUES);
		for (int v = VALUES - 1; v >= 0; v--) begin
			if (!present[v]) res.mex = MEX_OUT_W'(v);
		end
		res.capped = (res.mex == MEX_OUT_W'(VALUES));
		return res;
	endfunction

	// mostly untracked values, some just above the tracked range, some tracked
	function automatic bit [VALUE_W-1:0] noise_value();
		case ($urandom_range(0, 3))
			0, 1:    return $urandom;
			2:       return $urandom_range(VALUES, VALUES + 15);
			default: return $urandom_range(0, VALUES - 1);
		endcase
	endfunction

	// offer one request, hold it until accepted, then record its expected result
	task automatic offer_request(input bit cmd, input bit [VALUE_W-1:0] val,
			input bit typed, input mex_result_t typed_res);
		mex_result_t res;
		if (tx_bursty && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		in_valid <= 1'b1;
		command  <= cmd;
		value    <= val;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		res = apply_request(cmd, val);
		expected_results.push_back(typed ? typed_res : res);
		items_sent++;
	endtask

	// sender: directed table, random episodes, then a back-to-back run on one value
	initial begin : stimulus
		directed_row_t row;
		episode_t      kind;
		int unsigned   order [VALUES];
		int unsigned   top;
		int unsigned   pick;
		int unsigned   swap;
		int unsigned   start;
		int unsigned   episode;
		bit [VALUE_W-1:0] last_val;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED[i]) begin
			row = DIRECTED[i];
			offer_request(row.cmd, row.val, row.typed, {row.mex, row.capped, row.err});
		end

		// random part: well-formed fills that push the mex up, drains that pull it down,
		// and noise with untracked values and removes of absent values
		start   = items_sent;
		episode = 0;
		while (items_sent - start < RANDOM_ITEMS) begin
			tx_bursty = ($urandom_range(0, 2) != 0);
			rx_bursty = ($urandom_range(0, 2) != 0);
			// once: stall the receiver for a long stretch while the sender keeps offering
			if (episode == 2) begin
				tx_bursty    = 1'b0;
				hold_off_req = 1'b1;
			end
			if (episode == 0) kind = EP_FULL_FILL;
			else case ($urandom_range(0, 7))
				0, 1, 2: kind = EP_FILL;
				3:       kind = EP_FULL_FILL;
				4, 5:    kind = EP_DRAIN;
				default: kind = EP_NOISE;
			endcase
			case (kind)
				EP_FILL, EP_FULL_FILL: begin
					top = (kind == EP_FULL_FILL) ? VALUES - 1 : $urandom_range(0, 100);
					for (int v = 0; v <= top; v++) order[v] = v;
					for (int v = top; v > 0; v--) begin
						pick        = $urandom_range(0, v);
						swap        = order[v];
						order[v]    = order[pick];
						order[pick] = swap;
					end
					for (int v = 0; v <= top; v++) begin
						if ($urandom_range(0, 7) == 0)
							offer_request($urandom_range(0, 1), noise_value(), PREDICTED, '0);
						offer_request(CMD_ADD, order[v], PREDICTED, '0);
					end
					// knock single values out of the filled range and put them back
					repeat ($urandom_range(2, 6)) begin
						pick = $urandom_range(0, top);
						offer_request(CMD_REMOVE, pick, PREDICTED, '0);
						offer_request(CMD_ADD, pick, PREDICTED, '0);
					end
				end
				EP_DRAIN: begin
					// low values are favored so the mex moves
					repeat ($urandom_range(10, 60)) begin
						pick = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 31)
							: $urandom_range(0, VALUES - 1);
						offer_request(CMD_REMOVE, pick, PREDICTED, '0);
					end
				end
				default: begin
					repeat ($urandom_range(10, 30))
						offer_request($urandom_range(0, 1), noise_value(), PREDICTED, '0);
				end
			endcase
			episode++;
		end

		// last part, no idling: stack copies of one value, remove them all and one more, then add it once more
		tx_bursty = 1'b0;
		rx_bursty = 1'b0;
		last_val  = $urandom_range(0, VALUES - 1);
		repeat (LAST_ADDS) offer_request(CMD_ADD, last_val, PREDICTED, '0);
		while (tally[last_val] != '0) offer_request(CMD_REMOVE, last_val, PREDICTED, '0);
		offer_request(CMD_REMOVE, last_val, PREDICTED, '0);
		offer_request(CMD_ADD, last_val, PREDICTED, '0);
		in_valid <= 1'b0;

		// wait for the outstanding results, then keep watching for anything stray
		while (expected_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && expected_results.size() == 0) begin
			$display("multiset_mex_tracker test passed");
		end else begin
			$display("multiset_mex_tracker test failed");
		end
		$finish;
	end

	// receiver: ready with random stall bursts, plus one long hold-off on request
	initial begin : receiver
		wait (arst_n === 1'b1);
		forever begin
			if (hold_off_req) begin
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				hold_off_req = 1'b0;
			end else if (rx_bursty && $urandom_range(0, 4) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 7)) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	// every accepted result against the oldest expectation
	always @(posedge clk) begin : check_results
		mex_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				fail_count++;
				if (fail_count <= REPORT_LIMIT)
					$display("%0t: result with no request pending: mex %0d capped %0b error %0b",
						$realtime, mex, mex_capped, error);
			end else begin
				want = expected_results.pop_front();
				if (mex !== want.mex || mex_capped !== want.capped || error !== want.err) begin
					fail_count++;
					if (fail_count <= REPORT_LIMIT)
						$display("%0t: mismatch: mex %0d/%0d capped %0b/%0b error %0b/%0b (exp/got)",
							$realtime, want.mex, mex, want.capped, mex_capped,
							want.err, error);
				end
			end
		end
	end

	// stop the run when neither channel has moved for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
				$display("multiset_mex_tracker test failed");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

endmodule

[multiset_mex_tracker.f]
+incdir+design
design/mmt_pkg.sv
design/mmt_ram.sv
design/mmt_ctrl.sv
design/mmt_dp.sv
design/multiset_mex_tracker.sv
design/mmt_checker.sv
tb/tb_multiset_mex_tracker.sv
